// ----- rtl/sab_pkg.sv -----
`timescale 1ns / 1ps

package sab_pkg;

   // Atlas limits and field widths
   localparam int MAX_ATLAS = 256;
   localparam int COL_W     = $clog2(MAX_ATLAS);
   localparam int DIM_W     = 9;
   localparam int POS_W     = 8;
   localparam int SUM_W     = DIM_W + 1;

   localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(128);
   localparam logic [DIM_W-1:0] MAX_SIZE   = DIM_W'(MAX_ATLAS);

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_CLEARED = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic       idle;
      logic       start;
      logic       clear;
      logic       check;
      logic       place;
      logic       write;
      logic       out_load;
      status_type out_status;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic req_clear;
      logic req_bad;
      logic scan_more;
      logic no_fit;
      logic write_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

// ----- rtl/sab_if.sv -----
`timescale 1ns / 1ps

// Request channel: one allocate or clear command
interface sab_req_if
   import sab_pkg::*;
();
   logic             valid;
   logic             ready;
   cmd_type          command;
   logic [DIM_W-1:0] block_width;
   logic [DIM_W-1:0] block_height;

   modport source(output valid, command, block_width, block_height, input ready);
   modport sink(input valid, command, block_width, block_height, output ready);
endinterface

// Response channel: placement or status
interface sab_rsp_if
   import sab_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   status_type       status;

   modport source(output valid, pos_x, pos_y, status, input ready);
   modport sink(input valid, pos_x, pos_y, status, output ready);
endinterface

// ----- rtl/sab_dpath.sv -----
`timescale 1ns / 1ps

module sab_dpath
   import sab_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data,
   sab_req_if.sink          req_if,
   sab_rsp_if.source        rsp_if,
   input  ctl_cmd_type      cmd,
   output dp_stat_type      stat
);

   // Column height store and its per-column valid bits
   logic [DIM_W-1:0]     heights [MAX_ATLAS];
   logic [MAX_ATLAS-1:0] valid_ff;
   logic [DIM_W-1:0]     rd_ff;
   logic                 rv_ff;

   logic [DIM_W-1:0] size_ff;
   logic [DIM_W-1:0] w_ff, h_ff;
   logic [COL_W:0]   start_ff, col_ff;
   logic [DIM_W-1:0] top_ff, best_ff;
   logic [COL_W-1:0] place_ff;
   logic             found_ff;

   logic             rsp_valid_ff;
   logic [POS_W-1:0] pos_x_ff, pos_y_ff;
   status_type       status_ff;

   logic [DIM_W-1:0] size_eff;
   logic [DIM_W-1:0] cur;
   logic [DIM_W-1:0] top_max;
   logic             blocked;
   logic             win_done;
   logic [COL_W:0]   col_inc;
   logic [COL_W:0]   start_inc;
   logic [COL_W:0]   start_in;
   logic [COL_W:0]   col_in;
   logic [DIM_W-1:0] fill_value;
   logic             accept;

   assign accept   = req_if.valid & req_if.ready;
   assign size_eff = (size_ff > MAX_SIZE) ? MAX_SIZE : size_ff;

   // Scan step: judge the column read last cycle against the current window
   always_comb begin
      cur       = rv_ff ? rd_ff : '0;
      blocked   = (cur >= best_ff);
      top_max   = (cur > top_ff) ? cur : top_ff;
      col_inc   = col_ff + 1'b1;
      start_inc = start_ff + 1'b1;
      win_done  = (SUM_W'(col_ff) + SUM_W'(1)) == (SUM_W'(start_ff) + SUM_W'(w_ff));
      if (blocked) begin
         start_in = col_inc;
         col_in   = col_inc;
      end else if (win_done) begin
         start_in = start_inc;
         col_in   = start_inc;
      end else begin
         start_in = start_ff;
         col_in   = col_inc;
      end
   end

   assign fill_value = best_ff + h_ff;

   // Status back to the controller
   always_comb begin
      stat.req_valid  = req_if.valid;
      stat.req_clear  = (req_if.command == CMD_CLEAR);
      stat.req_bad    = (req_if.block_width == '0) || (req_if.block_height == '0) ||
                        (req_if.block_width > size_eff);
      stat.scan_more  = (SUM_W'(start_in) + SUM_W'(w_ff)) <= SUM_W'(size_eff);
      stat.no_fit     = !found_ff ||
                        ((SUM_W'(best_ff) + SUM_W'(h_ff)) > SUM_W'(size_eff));
      stat.write_last = (SUM_W'(col_ff) + SUM_W'(1)) == (SUM_W'(place_ff) + SUM_W'(w_ff));
      stat.rsp_free   = !rsp_valid_ff || rsp_if.ready;
   end

   assign req_if.ready = cmd.idle;

   // Atlas size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Height store: registered read at the column pointer, write while raising
   always_ff @(posedge clock) begin
      rd_ff <= heights[col_ff[COL_W-1:0]];
      if (cmd.write) begin
         heights[col_ff[COL_W-1:0]] <= fill_value;
      end
   end

   // Valid bits: drop all on reset or clear, set on each write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= valid_ff[col_ff[COL_W-1:0]];
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.write) begin
            valid_ff[col_ff[COL_W-1:0]] <= 1'b1;
         end
      end
   end

   // Scan and placement registers
   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff <= req_if.block_width;
         h_ff <= req_if.block_height;
      end
      if (cmd.start) begin
         start_ff <= '0;
         col_ff   <= '0;
         top_ff   <= '0;
         best_ff  <= size_eff;
         found_ff <= 1'b0;
      end else if (cmd.check) begin
         start_ff <= start_in;
         col_ff   <= col_in;
         top_ff   <= (blocked || win_done) ? '0 : top_max;
         if (!blocked && win_done) begin
            found_ff <= 1'b1;
            place_ff <= start_ff[COL_W-1:0];
            best_ff  <= top_max;
         end
      end else if (cmd.place) begin
         col_ff <= {1'b0, place_ff};
      end else if (cmd.write) begin
         col_ff <= col_inc;
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         if (cmd.out_status == ST_PLACED) begin
            pos_x_ff <= POS_W'(place_ff);
            pos_y_ff <= best_ff[POS_W-1:0];
         end else begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
         end
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.pos_x  = pos_x_ff;
   assign rsp_if.pos_y  = pos_y_ff;
   assign rsp_if.status = status_ff;

endmodule

// ----- rtl/sab_ctrl.sv -----
`timescale 1ns / 1ps

module sab_ctrl
   import sab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_EVAL,
      S_WRITE,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type res_ff, res_in;

   // Decode commands and next state
   always_comb begin
      cmd            = '0;
      cmd.out_status = res_ff;
      state_in       = state_ff;
      res_in         = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_valid) begin
               if (stat.req_clear) begin
                  cmd.clear = 1'b1;
                  res_in    = ST_CLEARED;
                  state_in  = S_DONE;
               end else if (stat.req_bad) begin
                  res_in   = ST_NO_ROOM;
                  state_in = S_DONE;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.scan_more ? S_READ : S_EVAL;
         end
         S_EVAL: begin
            if (stat.no_fit) begin
               res_in   = ST_NO_ROOM;
               state_in = S_DONE;
            end else begin
               cmd.place = 1'b1;
               res_in    = ST_PLACED;
               state_in  = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            if (stat.write_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and result code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= ST_NO_ROOM;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule

// ----- rtl/skyline_atlas_block_allocator.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Contents
// req_if    in         command, block_width, block_height
// rsp_if    out        pos_x, pos_y, status
// csr       in         csr_wr_en, csr_wr_data (atlas_size)
//
// A clear or a rejected request goes from idle straight to the done state, which loads
// the output register once it is free. An allocation reads one column height at a time
// (registered read, read then check state), restarting past any column that blocks the
// window, then writes block_width columns one per cycle.
// Reset and clear drop one valid bit per column at once; no clearing pass.
// A new request is taken while the previous response waits to be taken.

module skyline_atlas_block_allocator
   import sab_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data,
   sab_req_if.sink          req_if,
   sab_rsp_if.source        rsp_if
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sab_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   sab_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ----- verif/skyline_atlas_placement_check.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps its own skyline,
// predicts the placement for every accepted request and compares each
// accepted response with the oldest prediction.
module skyline_atlas_placement_check
   import sab_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data,
   sab_req_if               req_mon,
   sab_rsp_if               rsp_mon,
   output int unsigned      mismatches,
   output int unsigned      outstanding
);

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      status_type       status;
   } placement_type;

   logic [DIM_W-1:0] atlas_size;
   logic [DIM_W-1:0] skyline [MAX_ATLAS];
   placement_type    placements_due [$];
   int unsigned      fail_total = 0;

   // Find the lowest window (first one wins a tie), then raise its columns
   function automatic placement_type place_block(cmd_type cmd, logic [DIM_W-1:0] bw,
                                                 logic [DIM_W-1:0] bh);
      placement_type res;
      int unsigned   side, best, peak, start, k, place_x;
      bit            found, clear_window;
      res = '{pos_x: '0, pos_y: '0, status: ST_NO_ROOM};
      if (cmd == CMD_CLEAR) begin
         foreach (skyline[i]) skyline[i] = '0;
         res.status = ST_CLEARED;
         return res;
      end
      side = (atlas_size > MAX_ATLAS) ? MAX_ATLAS : atlas_size;
      if (bw == 0 || bh == 0 || bw > side) begin
         return res;
      end
      best    = side;
      found   = 1'b0;
      place_x = 0;
      for (start = 0; start + bw <= side; start++) begin
         peak         = 0;
         clear_window = 1'b1;
         for (k = 0; k < bw; k++) begin
            if (skyline[start + k] >= best) begin
               clear_window = 1'b0;
               break;
            end
            if (skyline[start + k] > peak) begin
               peak = skyline[start + k];
            end
         end
         if (clear_window) begin
            place_x = start;
            best    = peak;
            found   = 1'b1;
         end
      end
      // Leave the skyline alone when nothing fits under the top edge
      if (!found || best + bh > side) begin
         return res;
      end
      for (k = 0; k < bw; k++) begin
         skyline[place_x + k] = DIM_W'(best + bh);
      end
      res.pos_x  = POS_W'(place_x);
      res.pos_y  = POS_W'(best);
      res.status = ST_PLACED;
      return res;
   endfunction

   // Track config, match responses first, then queue the new prediction
   always @(posedge clock) begin
      placement_type due;
      placement_type got;
      bit            bad;
      if (reset) begin
         atlas_size = SIZE_RESET;
         foreach (skyline[i]) skyline[i] = '0;
         placements_due.delete();
      end else begin
         if (csr_wr_en) begin
            atlas_size = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{pos_x: rsp_mon.pos_x, pos_y: rsp_mon.pos_y, status: rsp_mon.status};
            if (placements_due.size() == 0) begin
               $display("%0t: response with none expected: x %0d y %0d status %0d",
                        $time, got.pos_x, got.pos_y, got.status);
               fail_total++;
            end else begin
               due = placements_due.pop_front();
               bad = 1'b0;
               if (got.pos_x !== due.pos_x) begin
                  $display("%0t: pos_x expected %0d actual %0d", $time, due.pos_x, got.pos_x);
                  bad = 1'b1;
               end
               if (got.pos_y !== due.pos_y) begin
                  $display("%0t: pos_y expected %0d actual %0d", $time, due.pos_y, got.pos_y);
                  bad = 1'b1;
               end
               if (got.status !== due.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, due.status,
                           got.status);
                  bad = 1'b1;
               end
               if (bad) begin
                  fail_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            placements_due.push_back(place_block(req_mon.command, req_mon.block_width,
                                                 req_mon.block_height));
         end
      end
      mismatches  <= fail_total;
      outstanding <= placements_due.size();
   end

endmodule

// ----- verif/skyline_atlas_block_allocator_test.sv -----
`timescale 1ns / 1ps

// Drives allocate and clear requests over several atlas sizes, with random
// idling on both channels and one long response stall, and reports the
// verdict from the placement checker.
module skyline_atlas_block_allocator_test;
   import sab_pkg::*;

   localparam int unsigned RUN_LIMIT    = 20_000_000;
   localparam int unsigned DRAIN_CYCLES = 1200;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned IDLE_PCT     = 24;
   localparam int unsigned PHASES       = 20;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [DIM_W-1:0] csr_wr_data;
   int unsigned      mismatches;
   int unsigned      outstanding;
   bit               steady;
   bit               squeeze;

   sab_req_if req_ch ();
   sab_rsp_if rsp_ch ();

   skyline_atlas_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch)
   );

   skyline_atlas_placement_check placement_check (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: random idling, one long hold-off when asked
   initial begin
      int unsigned hold_left;
      bit          squeezed;
      hold_left    = 0;
      squeezed     = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            hold_left = HOLD_CYCLES;
            squeezed  = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offer one request, maybe after a gap, and hold it until taken
   task automatic send_request(input cmd_type cmd, input logic [DIM_W-1:0] bw,
                               input logic [DIM_W-1:0] bh);
      int unsigned gap;
      gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.block_width  <= bw;
      req_ch.block_height <= bh;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drain all responses, then change the atlas size
   task automatic write_atlas_size(input logic [DIM_W-1:0] value);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small blocks that fill the atlas, plus clears, zero-sized, wide and raw sizes
   task automatic send_random(input int unsigned eff);
      int unsigned      pick;
      int unsigned      reach;
      logic [DIM_W-1:0] bw;
      logic [DIM_W-1:0] bh;
      pick  = $urandom_range(99);
      reach = (eff < 4) ? 1 : eff / 4;
      if (pick < 5) begin
         send_request(CMD_CLEAR, DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)));
      end else if (pick < 15 || eff == 0) begin
         send_request(CMD_ALLOC, DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)));
      end else if (pick < 18) begin
         bw = DIM_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, eff));
         bh = (bw == 0) ? DIM_W'($urandom_range(511)) : '0;
         send_request(CMD_ALLOC, bw, bh);
      end else if (pick < 25) begin
         send_request(CMD_ALLOC, DIM_W'($urandom_range(1, eff)), DIM_W'($urandom_range(1, eff)));
      end else begin
         send_request(CMD_ALLOC, DIM_W'($urandom_range(1, reach)),
                      DIM_W'($urandom_range(1, reach)));
      end
   endtask

   initial begin
      int unsigned      phase;
      int unsigned      n;
      int unsigned      count;
      int unsigned      eff;
      logic [DIM_W-1:0] size_val;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_ALLOC;
      req_ch.block_width  = '0;
      req_ch.block_height = '0;
      steady              = 1'b0;
      squeeze             = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default size: corner placements, rejects, ties, full atlas
      send_request(CMD_ALLOC, 9'd1, 9'd1);
      send_request(CMD_ALLOC, 9'd128, 9'd1);
      send_request(CMD_ALLOC, 9'd129, 9'd1);
      send_request(CMD_ALLOC, 9'd0, 9'd5);
      send_request(CMD_ALLOC, 9'd4, 9'd0);
      send_request(CMD_ALLOC, 9'd511, 9'd511);
      send_request(CMD_ALLOC, 9'd10, 9'd200);
      send_request(CMD_ALLOC, 9'd8, 9'd126);
      send_request(CMD_ALLOC, 9'd8, 9'd5);
      send_request(CMD_ALLOC, 9'd120, 9'd1);
      send_request(CMD_CLEAR, 9'd0, 9'd0);
      send_request(CMD_ALLOC, 9'd128, 9'd128);
      send_request(CMD_ALLOC, 9'd1, 9'd1);
      send_request(CMD_CLEAR, 9'd511, 9'd511);

      // Empty atlas rejects everything
      write_atlas_size(9'd0);
      send_request(CMD_ALLOC, 9'd1, 9'd1);

      // One-texel atlas fills at once
      write_atlas_size(9'd1);
      send_request(CMD_ALLOC, 9'd1, 9'd1);
      send_request(CMD_ALLOC, 9'd1, 9'd1);

      // Oversized register clamps to the maximum; reach the last column and top row
      write_atlas_size(9'h1FF);
      send_request(CMD_CLEAR, 9'd0, 9'd0);
      send_request(CMD_ALLOC, 9'd255, 9'd10);
      send_request(CMD_ALLOC, 9'd1, 9'd1);
      send_request(CMD_ALLOC, 9'd1, 9'd255);
      send_request(CMD_ALLOC, 9'd256, 9'd1);
      send_request(CMD_ALLOC, 9'd1, 9'd246);

      // Random phases over a range of atlas sizes
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               size_val = 9'd16;
            end
            3: begin
               size_val = MAX_SIZE;
            end
            5: begin
               size_val = 9'h1FF;
            end
            7: begin
               size_val = '0;
            end
            11: begin
               size_val = SIZE_RESET;
            end
            default: begin
               size_val = ($urandom_range(3) == 0) ? DIM_W'($urandom_range(65, 200))
                                                   : DIM_W'($urandom_range(1, 64));
            end
         endcase
         write_atlas_size(size_val);
         squeeze <= (phase == 1);
         steady  <= (phase == 2);
         eff   = (size_val > MAX_ATLAS) ? MAX_ATLAS : size_val;
         count = (eff == 0) ? 10 : (eff > 128) ? 30 : 55;
         for (n = 0; n < count; n++) begin
            send_random(eff);
         end
      end

      // Wait out the last responses, then watch for strays
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sab_pkg.sv
rtl/sab_if.sv
rtl/sab_dpath.sv
rtl/sab_ctrl.sv
rtl/skyline_atlas_block_allocator.sv
verif/skyline_atlas_placement_check.sv
verif/skyline_atlas_block_allocator_test.sv
